// ===== rtl/stum_pkg.sv =====
// Package for the stage time utilization monitor.
// Holds the event codes, register indexes, queue sizing and shared types.
// No dependencies.
package stum_pkg;

   localparam int NUM_SLOTS_DEFAULT = 4;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_INDEX_W = 2;

   localparam logic [1:0] REQ_START = 2'd0;
   localparam logic [1:0] REQ_END = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_COUNT = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_REPORT_TIME = CSR_INDEX_W'(1);

   typedef enum logic [1:0] {
      EV_START = 2'd0,
      EV_END = 2'd1,
      EV_CLEAR = 2'd2
   } stum_op_type;

   typedef struct packed {
      stum_op_type op;
      logic [1:0] slot;
      logic [31:0] time_us;
      logic [31:0] value;
   } stum_event_type;

   typedef enum logic {
      BK_RUN = 1'b0,
      BK_REPORT = 1'b1
   } stum_back_state_type;

endpackage

// ===== rtl/stum_front.sv =====
// Front end of the monitor: accepts request items, drops those that do nothing
// and classifies the rest into queue events.
// Depends on stum_pkg.
module stum_front import stum_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_type,
   input logic [1:0] req_slot_index,
   input logic [31:0] req_time_us,
   input logic [31:0] req_value,
   input logic q_full,
   output logic q_push,
   output stum_event_type q_push_event
);

   logic slot_ok;
   logic keep;
   stum_op_type op;

   assign slot_ok = 32'(req_slot_index) < 32'(NUM_SLOTS);

   always_comb begin
      keep = 1'b0;
      op = EV_START;
      case (req_type)
         REQ_CLEAR: begin
            keep = 1'b1;
            op = EV_CLEAR;
         end
         REQ_START: begin
            keep = slot_ok;
            op = EV_START;
         end
         REQ_END: begin
            keep = slot_ok;
            op = EV_END;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = q_full;
   assign q_push = req_valid && !q_full && keep;
   assign q_push_event = '{op: op, slot: req_slot_index, time_us: req_time_us,
                           value: req_value};

endmodule

// ===== rtl/stum_queue.sv =====
// Short event queue between the front end and the back end.
// Register based, so each side can stall on its own.
// Depends on stum_pkg.
module stum_queue import stum_pkg::*; (
   input logic clock,
   input logic reset,
   input logic q_push,
   input stum_event_type q_push_event,
   output logic q_full,
   output logic q_valid,
   output stum_event_type q_event,
   input logic q_pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

   stum_event_type entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign q_full = count_ff == CNT_W'(QUEUE_DEPTH);
   assign q_valid = count_ff != '0;
   assign q_event = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (q_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (q_push && !q_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (q_pop && !q_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_push) begin
         entries_ff[wr_ptr_ff] <= q_push_event;
      end
   end

`ifndef SYNTH
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("queue written while full");
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("queue read while empty");
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
`endif

endmodule

// ===== rtl/stum_back.sv =====
// Back end of the monitor: holds the slot timing state and the report
// thresholds, executes queued events and sends report records out.
// Depends on stum_pkg.
module stum_back import stum_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic q_valid,
   input stum_event_type q_event,
   output logic q_pop,
   input logic csr_valid,
   output logic csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [31:0] csr_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_report_slot,
   output logic [63:0] rsp_slot_busy_us,
   output logic [31:0] rsp_window_us,
   output logic [31:0] rsp_pass_count,
   output logic [31:0] rsp_total_value,
   output logic rsp_last
);

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

   stum_back_state_type state_ff, state_in;
   logic [SLOT_W-1:0] rpt_k_ff, rpt_k_in;

   logic [31:0] report_count_ff, report_count_in;
   logic [31:0] report_time_ff, report_time_in;

   logic restart_pending_ff, restart_pending_in;
   logic [31:0] window_start_ff, window_start_in;
   logic [31:0] slot_start_ff [NUM_SLOTS];
   logic [31:0] slot_start_in [NUM_SLOTS];
   logic [63:0] busy_ff [NUM_SLOTS];
   logic [63:0] busy_in [NUM_SLOTS];
   logic [31:0] end_count_ff, end_count_in;
   logic [31:0] value_total_ff, value_total_in;
   logic [31:0] elapsed_ff, elapsed_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_slot_ff, rsp_slot_in;
   logic [63:0] rsp_busy_ff, rsp_busy_in;
   logic [31:0] rsp_window_ff, rsp_window_in;
   logic [31:0] rsp_pass_ff, rsp_pass_in;
   logic [31:0] rsp_total_ff, rsp_total_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_load;
   logic [SLOT_W-1:0] ev_slot;
   logic [SLOT_W-1:0] nxt_slot;
   logic [31:0] slot_diff;
   logic [31:0] elapsed_new;
   logic [63:0] busy_new;
   logic [31:0] end_count_new;
   logic is_last;
   logic fire;
   logic end_fire;

   assign csr_ready = 1'b1;

   // Event arithmetic.
   always_comb begin
      ev_slot = SLOT_W'(q_event.slot);
      nxt_slot = (ev_slot == LAST_SLOT) ? ev_slot : ev_slot + SLOT_W'(1);
      slot_diff = q_event.time_us - slot_start_ff[ev_slot];
      elapsed_new = q_event.time_us - window_start_ff;
      busy_new = busy_ff[ev_slot] + {32'd0, slot_diff};
      end_count_new = end_count_ff + 32'(ev_slot == '0);
      is_last = (ev_slot == LAST_SLOT) || (busy_ff[nxt_slot] == 64'd0);
      fire = is_last &&
             ((report_time_ff != 32'd0 && elapsed_new >= report_time_ff) ||
              (report_count_ff != 32'd0 && end_count_new >= report_count_ff));
      end_fire = q_pop && (q_event.op == EV_END) && fire;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_RUN: begin
            if (end_fire) begin
               state_in = BK_REPORT;
            end
         end
         BK_REPORT: begin
            if (out_load && rpt_k_ff == LAST_SLOT) begin
               state_in = BK_RUN;
            end
         end
         default: begin
            state_in = BK_RUN;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      q_pop = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_RUN: begin
            q_pop = q_valid;
         end
         BK_REPORT: begin
            out_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // Slot state update.
   always_comb begin
      restart_pending_in = restart_pending_ff;
      window_start_in = window_start_ff;
      slot_start_in = slot_start_ff;
      busy_in = busy_ff;
      end_count_in = end_count_ff;
      value_total_in = value_total_ff;
      elapsed_in = elapsed_ff;
      if (q_pop) begin
         case (q_event.op)
            EV_CLEAR: begin
               restart_pending_in = 1'b1;
               window_start_in = '0;
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  slot_start_in[i] = '0;
                  busy_in[i] = '0;
               end
               end_count_in = '0;
               value_total_in = '0;
               elapsed_in = '0;
            end
            EV_START: begin
               if (restart_pending_ff) begin
                  restart_pending_in = 1'b0;
                  window_start_in = q_event.time_us;
                  for (int i = 0; i < NUM_SLOTS; i++) begin
                     slot_start_in[i] = '0;
                     busy_in[i] = '0;
                  end
                  end_count_in = '0;
                  value_total_in = '0;
                  elapsed_in = '0;
               end
               slot_start_in[ev_slot] = q_event.time_us;
            end
            EV_END: begin
               elapsed_in = elapsed_new;
               value_total_in = value_total_ff + q_event.value;
               end_count_in = end_count_new;
               busy_in[ev_slot] = busy_new;
               if (fire) begin
                  restart_pending_in = 1'b1;
               end
            end
            default: begin
               elapsed_in = elapsed_ff;
            end
         endcase
      end
   end

   // Report sequencing and output register.
   always_comb begin
      rpt_k_in = rpt_k_ff;
      if (end_fire) begin
         rpt_k_in = '0;
      end else if (out_load && rpt_k_ff != LAST_SLOT) begin
         rpt_k_in = rpt_k_ff + SLOT_W'(1);
      end
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
      rsp_slot_in = rsp_slot_ff;
      rsp_busy_in = rsp_busy_ff;
      rsp_window_in = rsp_window_ff;
      rsp_pass_in = rsp_pass_ff;
      rsp_total_in = rsp_total_ff;
      rsp_last_in = rsp_last_ff;
      if (out_load) begin
         rsp_slot_in = 2'(rpt_k_ff);
         rsp_busy_in = busy_ff[rpt_k_ff];
         rsp_window_in = elapsed_ff;
         rsp_pass_in = end_count_ff;
         rsp_total_in = value_total_ff;
         rsp_last_in = rpt_k_ff == LAST_SLOT;
      end
   end

   always_comb begin
      report_count_in = report_count_ff;
      report_time_in = report_time_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REPORT_COUNT: begin
               report_count_in = csr_data;
            end
            CSR_REPORT_TIME: begin
               report_time_in = csr_data;
            end
            default: begin
               report_count_in = report_count_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_RUN;
         rpt_k_ff <= '0;
         report_count_ff <= '0;
         report_time_ff <= '0;
         restart_pending_ff <= 1'b1;
         window_start_ff <= '0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            slot_start_ff[i] <= '0;
            busy_ff[i] <= '0;
         end
         end_count_ff <= '0;
         value_total_ff <= '0;
         elapsed_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rpt_k_ff <= rpt_k_in;
         report_count_ff <= report_count_in;
         report_time_ff <= report_time_in;
         restart_pending_ff <= restart_pending_in;
         window_start_ff <= window_start_in;
         slot_start_ff <= slot_start_in;
         busy_ff <= busy_in;
         end_count_ff <= end_count_in;
         value_total_ff <= value_total_in;
         elapsed_ff <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_slot_ff <= rsp_slot_in;
      rsp_busy_ff <= rsp_busy_in;
      rsp_window_ff <= rsp_window_in;
      rsp_pass_ff <= rsp_pass_in;
      rsp_total_ff <= rsp_total_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_report_slot = rsp_slot_ff;
   assign rsp_slot_busy_us = rsp_busy_ff;
   assign rsp_window_us = rsp_window_ff;
   assign rsp_pass_count = rsp_pass_ff;
   assign rsp_total_value = rsp_total_ff;
   assign rsp_last = rsp_last_ff;

`ifndef SYNTH
   a_fire_starts_report: assert property (@(posedge clock) disable iff (reset)
      end_fire |=> state_ff == BK_REPORT && restart_pending_ff && rpt_k_ff == '0)
      else $error("report run did not start after a trigger");
   a_last_record_ends_run: assert property (@(posedge clock) disable iff (reset)
      (out_load && rpt_k_ff == LAST_SLOT) |=> state_ff == BK_RUN && rsp_last_ff)
      else $error("report run did not end on its final record");
   a_state_frozen_in_report: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_REPORT |=> $stable(end_count_ff) && $stable(value_total_ff))
      else $error("slot state changed during a report run");
`endif

endmodule

// ===== rtl/stage_time_utilization_monitor_unit.sv =====
// Top level of the stage time utilization monitor.
// Instantiates stum_front, stum_queue and stum_back; depends on stum_pkg.
// The unit takes one start, end or clear event per cycle into a two-entry
// queue while the queue is not full, and executes one queued event per
// cycle outside report runs; an event leaves no result except an end that
// triggers a report. A report run emits NUM_SLOTS records, one per cycle
// from the output register while rsp_stall is low, the first one loaded
// once the back end has entered its report state after the triggering end
// is executed, and the back end executes no further events until the last
// record is loaded. csr_ready is always high; thresholds must be written
// only while the unit is idle, which the unit does not enforce itself.
module stage_time_utilization_monitor_unit import stum_pkg::*; #(
   parameter int NUM_SLOTS = NUM_SLOTS_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input logic [1:0] req_type,
   input logic [1:0] req_slot_index,
   input logic [31:0] req_time_us,
   input logic [31:0] req_value,
   input logic csr_valid,
   output logic csr_ready,
   input logic [CSR_INDEX_W-1:0] csr_index,
   input logic [31:0] csr_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output logic [1:0] rsp_report_slot,
   output logic [63:0] rsp_slot_busy_us,
   output logic [31:0] rsp_window_us,
   output logic [31:0] rsp_pass_count,
   output logic [31:0] rsp_total_value,
   output logic rsp_last
);

   logic q_full;
   logic q_push;
   stum_event_type q_push_event;
   logic q_valid;
   stum_event_type q_event;
   logic q_pop;

   stum_front #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_front (
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_slot_index(req_slot_index),
      .req_time_us(req_time_us),
      .req_value(req_value),
      .q_full(q_full),
      .q_push(q_push),
      .q_push_event(q_push_event)
   );

   stum_queue u_queue (
      .clock(clock),
      .reset(reset),
      .q_push(q_push),
      .q_push_event(q_push_event),
      .q_full(q_full),
      .q_valid(q_valid),
      .q_event(q_event),
      .q_pop(q_pop)
   );

   stum_back #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_event(q_event),
      .q_pop(q_pop),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_report_slot(rsp_report_slot),
      .rsp_slot_busy_us(rsp_slot_busy_us),
      .rsp_window_us(rsp_window_us),
      .rsp_pass_count(rsp_pass_count),
      .rsp_total_value(rsp_total_value),
      .rsp_last(rsp_last)
   );

endmodule

// ===== bench/stage_time_utilization_monitor_unit_tb.sv =====
// Testbench for stage_time_utilization_monitor_unit: a directed table, then random stage passes.
// Every report record is checked against a predictor kept in this bench or a typed table row.
// Depends on stum_pkg and the unit's RTL only.
module stage_time_utilization_monitor_unit_tb import stum_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NSLOT = NUM_SLOTS_DEFAULT;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 12;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic [1:0] slot;
      logic [63:0] busy;
      logic [31:0] win;
      logic [31:0] passes;
      logic [31:0] total;
      logic last;
   } record_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] slot;
      logic [31:0] at;
      logic [31:0] val;
      logic typed;
      logic [3:0][63:0] busy;
      logic [31:0] win;
      logic [31:0] passes;
      logic [31:0] total;
   } step_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_type = REQ_START;
   logic [1:0] req_slot_index = 2'd0;
   logic [31:0] req_time_us = 32'd0;
   logic [31:0] req_value = 32'd0;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_REPORT_COUNT;
   logic [31:0] csr_data = 32'd0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_report_slot;
   logic [63:0] rsp_slot_busy_us;
   logic [31:0] rsp_window_us;
   logic [31:0] rsp_pass_count;
   logic [31:0] rsp_total_value;
   logic rsp_last;

   stage_time_utilization_monitor_unit dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_slot_index(req_slot_index),
      .req_time_us(req_time_us),
      .req_value(req_value),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_report_slot(rsp_report_slot),
      .rsp_slot_busy_us(rsp_slot_busy_us),
      .rsp_window_us(rsp_window_us),
      .rsp_pass_count(rsp_pass_count),
      .rsp_total_value(rsp_total_value),
      .rsp_last(rsp_last)
   );

   // Predictor state, mirroring the unit after reset.
   logic [31:0] cfg_passes = 32'd0;
   logic [31:0] cfg_span = 32'd0;
   logic armed = 1'b1;
   logic [31:0] win_t0 = 32'd0;
   logic [31:0] slot_t0 [NSLOT];
   logic [63:0] slot_busy [NSLOT];
   logic [31:0] npass = 32'd0;
   logic [31:0] vsum = 32'd0;
   logic [31:0] elapsed = 32'd0;
   record_type pred_run [NSLOT];

   record_type pending_records [$];
   step_row_type plan [$];
   logic [31:0] now_us = 32'd0;
   bit req_idle_en = 1'b1;
   bit rsp_idle_en = 1'b1;
   int errors = 0;
   int events_sent = 0;
   int records_seen = 0;
   int reports_fired = 0;
   int settings_used = 0;
   int quiet_cycles = 0;

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_stall <= rsp_idle_en && ($urandom_range(99) < 33);
   end

   function automatic step_row_type mk_row(input logic [1:0] kind, input logic [1:0] slot,
                                           input logic [31:0] at, input logic [31:0] val);
      step_row_type row;
      row = '0;
      row.kind = kind;
      row.slot = slot;
      row.at = at;
      row.val = val;
      return row;
   endfunction

   function automatic step_row_type mk_typed(input logic [1:0] kind, input logic [1:0] slot,
                                             input logic [31:0] at, input logic [31:0] val,
                                             input logic [63:0] b0, input logic [63:0] b1,
                                             input logic [63:0] b2, input logic [63:0] b3,
                                             input logic [31:0] win,
                                             input logic [31:0] passes,
                                             input logic [31:0] total);
      step_row_type row;
      row = mk_row(kind, slot, at, val);
      row.typed = 1'b1;
      row.busy[0] = b0;
      row.busy[1] = b1;
      row.busy[2] = b2;
      row.busy[3] = b3;
      row.win = win;
      row.passes = passes;
      row.total = total;
      return row;
   endfunction

   task automatic wipe_window();
      win_t0 = 32'd0;
      for (int k = 0; k < NSLOT; k++) begin
         slot_t0[k] = 32'd0;
         slot_busy[k] = 64'd0;
      end
      npass = 32'd0;
      vsum = 32'd0;
      elapsed = 32'd0;
      armed = 1'b1;
   endtask

   task automatic track_event(input logic [1:0] kind, input logic [1:0] slot,
                              input logic [31:0] at, input logic [31:0] val, output int n);
      logic [31:0] span;
      logic last_slot;
      n = 0;
      if (kind == REQ_CLEAR) begin
         wipe_window();
      end else if (kind == REQ_START) begin
         if (armed) begin
            wipe_window();
            armed = 1'b0;
            win_t0 = at;
         end
         slot_t0[slot] = at;
      end else if (kind == REQ_END) begin
         elapsed = at - win_t0;
         vsum = vsum + val;
         if (slot == 2'd0) npass = npass + 32'd1;
         span = at - slot_t0[slot];
         slot_busy[slot] = slot_busy[slot] + {32'd0, span};
         if (int'(slot) == NSLOT - 1) last_slot = 1'b1;
         else last_slot = (slot_busy[int'(slot) + 1] == 64'd0);
         if (last_slot && ((cfg_span != 0 && elapsed >= cfg_span) ||
                           (cfg_passes != 0 && npass >= cfg_passes))) begin
            for (int k = 0; k < NSLOT; k++) begin
               pred_run[k].slot = 2'(k);
               pred_run[k].busy = slot_busy[k];
               pred_run[k].win = elapsed;
               pred_run[k].passes = npass;
               pred_run[k].total = vsum;
               pred_run[k].last = (k == NSLOT - 1);
            end
            armed = 1'b1;
            n = NSLOT;
         end
      end
   endtask

   task automatic put_event(input step_row_type row);
      int n;
      record_type rec;
      if (req_idle_en && $urandom_range(99) < 33) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while (req_idle_en && $urandom_range(99) < 33) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type <= row.kind;
      req_slot_index <= row.slot;
      req_time_us <= row.at;
      req_value <= row.val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      track_event(row.kind, row.slot, row.at, row.val, n);
      if (row.typed) begin
         for (int k = 0; k < NSLOT; k++) begin
            rec.slot = 2'(k);
            rec.busy = row.busy[k];
            rec.win = row.win;
            rec.passes = row.passes;
            rec.total = row.total;
            rec.last = (k == NSLOT - 1);
            pending_records.push_back(rec);
         end
      end else begin
         for (int k = 0; k < n; k++) pending_records.push_back(pred_run[k]);
      end
      if (n != 0) reports_fired++;
      events_sent++;
      @(negedge clock);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (pending_records.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_thresholds(input logic [31:0] passes, input logic [31:0] span_us);
      csr_valid <= 1'b1;
      csr_index <= CSR_REPORT_COUNT;
      csr_data <= passes;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_passes = passes;
      @(negedge clock);
      csr_index <= CSR_REPORT_TIME;
      csr_data <= span_us;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_span = span_us;
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input logic [31:0] passes, input logic [31:0] span_us,
                            input int budget);
      int sent;
      int nst;
      logic [1:0] kind;
      quiesce();
      set_thresholds(passes, span_us);
      sent = 0;
      while (sent < budget) begin
         if ($urandom_range(99) < 80) begin
            nst = $urandom_range(1, NSLOT);
            if ($urandom_range(9) == 0) now_us = $urandom();
            for (int k = 0; k < nst; k++) begin
               put_event(mk_row(REQ_START, 2'(k), now_us, $urandom()));
               now_us = now_us + $urandom_range(1, 300);
               put_event(mk_row(REQ_END, 2'(k), now_us,
                                $urandom_range(1) ? $urandom() : $urandom_range(1000)));
            end
            sent += 2 * nst;
            now_us = now_us + $urandom_range(0, 100);
         end else begin
            kind = 2'($urandom_range(3));
            put_event(mk_row(kind, 2'($urandom_range(3)),
                             $urandom_range(1) ? $urandom() : now_us, $urandom()));
            if (kind != REQ_UNUSED) sent++;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      record_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_records.size() == 0) begin
            $error("report record for slot %0d arrived with none expected", rsp_report_slot);
            errors++;
         end else begin
            want = pending_records.pop_front();
            check_field("report_slot", 64'(want.slot), 64'(rsp_report_slot));
            check_field("slot_busy_us", want.busy, rsp_slot_busy_us);
            check_field("window_us", 64'(want.win), 64'(rsp_window_us));
            check_field("pass_count", 64'(want.passes), 64'(rsp_pass_count));
            check_field("total_value", 64'(want.total), 64'(rsp_total_value));
            check_field("last", 64'(want.last), 64'(rsp_last));
            records_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("Watchdog: no handshake for %0d cycles.", QUIET_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      for (int k = 0; k < NSLOT; k++) begin
         slot_t0[k] = 32'd0;
         slot_busy[k] = 64'd0;
      end
      plan.push_back(mk_row(REQ_END, 2'd2, 32'd100, 32'd5));
      plan.push_back(mk_row(REQ_START, 2'd0, 32'd1000, 32'd0));
      plan.push_back(mk_typed(REQ_END, 2'd0, 32'd1010, 32'hFFFF_FFFF,
                              64'd10, 64'd0, 64'd0, 64'd0, 32'd10, 32'd1, 32'hFFFF_FFFF));
      plan.push_back(mk_row(REQ_START, 2'd1, 32'hFFFF_FFF0, 32'd0));
      plan.push_back(mk_row(REQ_END, 2'd1, 32'h0000_0010, 32'd1));
      plan.push_back(mk_row(REQ_START, 2'd0, 32'h0000_0020, 32'd0));
      plan.push_back(mk_row(REQ_END, 2'd0, 32'h0000_001F, 32'd2));
      plan.push_back(mk_typed(REQ_END, 2'd3, 32'h0000_0030, 32'd0,
                              64'hFFFF_FFFF, 64'h20, 64'd0, 64'h30, 32'h40, 32'd1, 32'd3));
      plan.push_back(mk_row(REQ_UNUSED, 2'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
      plan.push_back(mk_row(REQ_CLEAR, 2'd3, 32'hAAAA_AAAA, 32'h5555_5555));
      plan.push_back(mk_row(REQ_END, 2'd3, 32'd5, 32'd7));
      plan.push_back(mk_typed(REQ_END, 2'd0, 32'd9, 32'd1,
                              64'd9, 64'd0, 64'd0, 64'd5, 32'd9, 32'd1, 32'd8));
      plan.push_back(mk_row(REQ_START, 2'd0, 32'h5555_5555, 32'd0));
      plan.push_back(mk_row(REQ_START, 2'd1, 32'h5555_5560, 32'd0));
      plan.push_back(mk_row(REQ_END, 2'd1, 32'h5555_5600, 32'h1234_5678));
      plan.push_back(mk_row(REQ_END, 2'd0, 32'h5555_5700, 32'h8000_0000));
      plan.push_back(mk_row(REQ_START, 2'd2, 32'h5555_5710, 32'd0));
      plan.push_back(mk_row(REQ_END, 2'd2, 32'hAAAA_AAAA, 32'h7FFF_FFFF));
      plan.push_back(mk_row(REQ_START, 2'd3, 32'd0, 32'hFFFF_FFFF));
      plan.push_back(mk_row(REQ_END, 2'd3, 32'hFFFF_FFFF, 32'd0));
      plan.push_back(mk_typed(REQ_END, 2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              64'hFFFF_FFFF, 64'd0, 64'd0, 64'hFFFF_FFFF,
                              32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_thresholds(32'd1, 32'd0);
      foreach (plan[i]) put_event(plan[i]);

      run_phase(32'd0, 32'd0, 40);
      run_phase(32'd3, 32'd0, 90);
      run_phase(32'd0, 32'd600, 90);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 30);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      run_phase(32'd2, 32'd1500, 90);
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
      run_phase(32'd1, 32'd1, 90);

      quiesce();
      repeat (20) @(posedge clock);
      $display("Sent %0d stage events under %0d threshold settings.", events_sent, settings_used);
      $display("Checked %0d report records from %0d reports.", records_seen, reports_fired);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/stum_pkg.sv
rtl/stum_front.sv
rtl/stum_queue.sv
rtl/stum_back.sv
rtl/stage_time_utilization_monitor_unit.sv
bench/stage_time_utilization_monitor_unit_tb.sv
